[rtl/core/rsp_pkg.sv]
package rsp_pkg;

	// Register and port widths
	localparam int unsigned FRAME_W    = 48;
	localparam int unsigned TIMEOUT_W  = 16;
	localparam int unsigned RETRY_W    = 4;
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 48;
	localparam int unsigned S_TDATA_W  = 8;
	localparam int unsigned S_TUSER_W  = 2;
	localparam int unsigned M_TDATA_W  = 32;

	// Operation codes (s_tuser)
	localparam logic [1:0] OP_POLL  = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RETRIES = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_NEW  = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;
	localparam logic [1:0] STATUS_FAIL = 2'd3;

	// Register reset values and counter limits
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [RETRY_W-1:0]   RETRIES_RESET = 4'd3;
	localparam logic [RETRY_W-1:0]   RETRY_MAX     = 4'hF;
	localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

	// Modbus CRC-16
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0]         tx_byte;
		logic               tx_valid;
		logic signed [15:0] reading;
		logic               mode;
		logic [1:0]         status;
		logic               last;
	} rsp_result_t;

endpackage

[rtl/core/rs485_sensor_poll_master.sv]
// A step that sends nothing shows its result, registered, in the cycle after acceptance.
// A sending step emits REQUEST_LEN + 2 bytes: each request byte goes bit-serially through
// the CRC and then into the output register, then the two CRC bytes; the sink can stall
// any byte. Throughput: one non-sending step per cycle while the sink does not stall; the
// next item waits for the frame's end.
// Reset: arst_n asynchronous, active low; clears all control state, registers to defaults.
module rs485_sensor_poll_master #(
	parameter int unsigned REQUEST_LEN  = 6,
	parameter int unsigned RESPONSE_LEN = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rsp_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] rx_byte
	input  logic [rsp_pkg::S_TUSER_W-1:0]      s_tuser,   // [1:0] operation
	// result side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rsp_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] tx_byte, [23:8] reading,
	                                                      // [24] mode, [26:25] status, zero above
	output logic                               m_tuser,   // [0] tx_valid
	output logic                               m_tlast
);

	localparam int unsigned CW  = $clog2(RESPONSE_LEN + 1);  // rx count, holds the depth
	localparam int unsigned IW  = $clog2(RESPONSE_LEN);      // rx store index
	localparam int unsigned IXW = $clog2(REQUEST_LEN + 2);   // frame byte index

	// Frame sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CRC  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Configuration registers
	logic [rsp_pkg::FRAME_W-1:0]   frame_q;
	logic [rsp_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [rsp_pkg::RETRY_W-1:0]   retries_q;

	// Poller state
	logic                          waiting_q, waiting_d;
	logic                          active_q, active_d;
	logic [CW-1:0]                 count_q, count_d;
	logic signed [15:0]            held_q, held_d;
	logic [rsp_pkg::TIMEOUT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [rsp_pkg::RETRY_W-1:0]   attempt_q, attempt_d;
	logic [7:0]                    rx_store_q [RESPONSE_LEN];
	logic [1:0]                    status_d;
	logic                          send;
	logic                          store_we;

	// Sequencer
	state_t                        st_q;
	logic [IXW-1:0]                idx_q;
	logic [2:0]                    bit_cnt_q;
	logic [7:0]                    bit_sh_q;
	logic [rsp_pkg::FRAME_W-1:0]   req_sh_q;
	logic [15:0]                   crc;
	logic [7:0]                    emit_byte;
	logic                          emit_last;

	// Output side
	logic                          accept;
	logic                          out_load;
	logic                          out_can_load;
	logic                          out_valid;
	rsp_pkg::rsp_result_t          out_data;
	rsp_pkg::rsp_result_t          out_q;

	// A request is taken only between frames and when the output slot is free
	assign s_tready = (st_q == ST_IDLE) && out_can_load;
	assign accept   = s_tvalid && s_tready;

	//------------------------------------------------------------------
	// Configuration
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			timeout_q <= rsp_pkg::TIMEOUT_RESET;
			retries_q <= rsp_pkg::RETRIES_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				rsp_pkg::REG_FRAME:   frame_q   <= cfg_data[rsp_pkg::FRAME_W-1:0];
				rsp_pkg::REG_TIMEOUT: timeout_q <= cfg_data[rsp_pkg::TIMEOUT_W-1:0];
				rsp_pkg::REG_RETRIES: retries_q <= cfg_data[rsp_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Step decode: next poller state for the request on the input
	//------------------------------------------------------------------
	assign elapsed_inc = (elapsed_q != rsp_pkg::ELAPSED_MAX) ?
	                     elapsed_q + 16'd1 : elapsed_q;

	always_comb begin
		waiting_d = waiting_q;
		active_d  = active_q;
		count_d   = count_q;
		held_d    = held_q;
		elapsed_d = elapsed_q;
		attempt_d = attempt_q;
		status_d  = rsp_pkg::STATUS_NONE;
		send      = 1'b0;
		store_we  = 1'b0;
		case (s_tuser)
			rsp_pkg::OP_POLL: begin
				if (!waiting_q) begin
					send = 1'b1;
				end else if (count_q >= CW'(RESPONSE_LEN)) begin
					// response complete: value is big-endian in bytes 3 and 4
					if ({rx_store_q[3], rx_store_q[4]} != 16'h0000) begin
						held_d   = {rx_store_q[3], rx_store_q[4]};
						status_d = rsp_pkg::STATUS_NEW;
					end else begin
						status_d = rsp_pkg::STATUS_ZERO;
					end
					count_d   = '0;
					waiting_d = 1'b0;
					active_d  = 1'b0;
				end
			end
			rsp_pkg::OP_RX: begin
				// bytes beyond a full store are dropped
				if (count_q < CW'(RESPONSE_LEN)) begin
					store_we = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			rsp_pkg::OP_TICK: begin
				// ticks count only while a read is armed and a reply is awaited
				if (active_q && waiting_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_q) begin
						if (attempt_q >= retries_q) begin
							waiting_d = 1'b0;
							active_d  = 1'b0;
							status_d  = rsp_pkg::STATUS_FAIL;
						end else begin
							send = 1'b1;
						end
					end
				end
			end
			rsp_pkg::OP_START: begin
				// abandons any wait and arms a fresh read
				active_d  = 1'b1;
				waiting_d = 1'b0;
				attempt_d = '0;
				elapsed_d = '0;
			end
			default: ;
		endcase
		if (send) begin
			count_d   = '0;
			waiting_d = 1'b1;
			elapsed_d = '0;
			// attempts counted only for an armed read, saturating
			if (active_q && attempt_q != rsp_pkg::RETRY_MAX) begin
				attempt_d = attempt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			active_q  <= 1'b0;
			count_q   <= '0;
			held_q    <= '0;
			elapsed_q <= '0;
			attempt_q <= '0;
		end else if (accept) begin
			waiting_q <= waiting_d;
			active_q  <= active_d;
			count_q   <= count_d;
			held_q    <= held_d;
			elapsed_q <= elapsed_d;
			attempt_q <= attempt_d;
		end
	end

	// Receive store: entries hold garbage until written, only ever read when full
	for (genvar e = 0; e < RESPONSE_LEN; e++) begin : g_store
		always_ff @(posedge clk) begin
			if (accept && store_we && count_q[IW-1:0] == IW'(e)) begin
				rx_store_q[e] <= s_tdata[7:0];
			end
		end
	end

	//------------------------------------------------------------------
	// Frame sequencer: each request byte is shifted LSB first through the
	// CRC and then put into the output register; the two CRC
	// bytes follow, low byte first.
	//------------------------------------------------------------------
	assign emit_last = (idx_q == IXW'(REQUEST_LEN + 1));

	always_comb begin
		if (idx_q < IXW'(REQUEST_LEN)) begin
			emit_byte = req_sh_q[rsp_pkg::FRAME_W-1 -: 8];
		end else if (idx_q == IXW'(REQUEST_LEN)) begin
			emit_byte = crc[7:0];
		end else begin
			emit_byte = crc[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			idx_q     <= '0;
			bit_cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept && send) begin
						st_q      <= ST_CRC;
						idx_q     <= '0;
						bit_cnt_q <= '0;
					end
				end
				ST_CRC: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_can_load) begin
						idx_q <= idx_q + IXW'(1);
						if (emit_last) begin
							st_q <= ST_IDLE;
						end else if (idx_q < IXW'(REQUEST_LEN - 1)) begin
							st_q <= ST_CRC;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Shift registers: request bytes leave from the top, zeros fill in behind
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && accept && send) begin
			req_sh_q <= frame_q;
			bit_sh_q <= frame_q[rsp_pkg::FRAME_W-1 -: 8];
		end else if (st_q == ST_CRC) begin
			bit_sh_q <= {1'b0, bit_sh_q[7:1]};
		end else if (st_q == ST_EMIT && out_can_load && idx_q < IXW'(REQUEST_LEN - 1)) begin
			req_sh_q <= {req_sh_q[rsp_pkg::FRAME_W-9:0], 8'h00};
			bit_sh_q <= req_sh_q[rsp_pkg::FRAME_W-9 -: 8];
		end
	end

	rsp_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (st_q == ST_IDLE && accept && send),
		.shift  (st_q == ST_CRC),
		.bit_in (bit_sh_q[0]),
		.crc    (crc)
	);

	//------------------------------------------------------------------
	// Output register
	//------------------------------------------------------------------
	assign out_load = (accept && !send) || (st_q == ST_EMIT && out_can_load);

	always_comb begin
		if (st_q == ST_EMIT) begin
			out_data.tx_byte  = emit_byte;
			out_data.tx_valid = 1'b1;
			out_data.reading  = held_q;
			out_data.mode     = waiting_q;
			out_data.status   = rsp_pkg::STATUS_NONE;
			out_data.last     = emit_last;
		end else begin
			// single result of a step that sends nothing
			out_data.tx_byte  = 8'h00;
			out_data.tx_valid = 1'b0;
			out_data.reading  = held_d;
			out_data.mode     = waiting_d;
			out_data.status   = status_d;
			out_data.last     = 1'b1;
		end
	end

	rsp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.data     (out_data),
		.ready    (m_tready),
		.valid    (out_valid),
		.q        (out_q),
		.can_load (out_can_load)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {5'b00000, out_q.status, out_q.mode, out_q.reading, out_q.tx_byte};
	assign m_tuser  = out_q.tx_valid;
	assign m_tlast  = out_q.last;

endmodule

[rtl/core/rsp_crc16.sv]
// Bit-serial Modbus CRC-16, data LSB first.
module rsp_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init,
	input  logic        shift,
	input  logic        bit_in,
	output logic [15:0] crc
);

	logic [15:0] crc_q;
	logic        fb;

	assign fb  = crc_q[0] ^ bit_in;
	assign crc = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= rsp_pkg::CRC_INIT;
		end else if (init) begin
			crc_q <= rsp_pkg::CRC_INIT;
		end else if (shift) begin
			crc_q <= {1'b0, crc_q[15:1]} ^ (fb ? rsp_pkg::CRC_POLY : 16'h0000);
		end
	end

endmodule

[rtl/core/rsp_out_reg.sv]
// One-entry output holding register.
module rsp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  rsp_pkg::rsp_result_t data,
	input  logic                 ready,
	output logic                 valid,
	output rsp_pkg::rsp_result_t q,
	output logic                 can_load
);

	logic                 valid_q;
	rsp_pkg::rsp_result_t data_q;

	assign valid    = valid_q;
	assign q        = data_q;
	assign can_load = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

endmodule

[rtl/core/rsp_checker.sv]
module rsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rsp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a result without a transmit byte is the only one of its step and carries a zero byte
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'h00)
		else $error("non-transmit result malformed");

	// frame bytes are sent while waiting, with no status
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[24] && m_tdata[26:25] == rsp_pkg::STATUS_NONE)
		else $error("frame byte with wrong mode or status");

	// any reported outcome leaves the poller idle
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[26:25] != rsp_pkg::STATUS_NONE |-> !m_tdata[24])
		else $error("outcome reported while still waiting");

	// padding above the packed fields stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:27] == 5'b00000)
		else $error("tdata padding not zero");

endmodule

bind rs485_sensor_poll_master rsp_checker u_rsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/tb_top.sv]
module tb_top;

	localparam int unsigned REQ_LEN     = 6;
	localparam int unsigned RSP_LEN     = 7;
	localparam int          IDLE_PCT    = 21;    // chance of a gap per cycle, per side
	localparam int          HOLD_CYCLES = 400;   // long sink hold-off, fills the block up
	localparam int          SETTLE      = 64;    // more than one full frame when the sink never stalls
	localparam int          WATCHDOG    = 4000;  // cycles with no handshake on either side

	// one stream request: operation in tuser, received byte in tdata
	typedef struct {
		logic [1:0] op;
		logic [7:0] rx;
	} poll_req_t;

	logic                               clk      = 1'b0;
	logic                               arst_n   = 1'b0;
	logic                               cfg_we   = 1'b0;
	logic [rsp_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
	logic [rsp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [rsp_pkg::S_TDATA_W-1:0]      s_tdata  = '0;    // [7:0] rx_byte
	logic [rsp_pkg::S_TUSER_W-1:0]      s_tuser  = '0;    // [1:0] operation
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [rsp_pkg::M_TDATA_W-1:0]      m_tdata;          // [7:0] tx_byte, [23:8] reading,
	                                                      // [24] mode, [26:25] status
	logic                               m_tuser;          // [0] tx_valid
	logic                               m_tlast;

	rs485_sensor_poll_master #(
		.REQUEST_LEN (REQ_LEN),
		.RESPONSE_LEN(RSP_LEN)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Poller prediction: own copy of registers and state
	// ---------------------------------------------------------------
	logic [rsp_pkg::FRAME_W-1:0]   frame_cfg   = '0;
	logic [rsp_pkg::TIMEOUT_W-1:0] timeout_cfg = rsp_pkg::TIMEOUT_RESET;
	logic [rsp_pkg::RETRY_W-1:0]   retries_cfg = rsp_pkg::RETRIES_RESET;

	logic        line_waiting = 1'b0;
	logic        read_armed   = 1'b0;
	logic [7:0]  rx_bytes [RSP_LEN];
	int          rx_fill      = 0;
	logic [15:0] held_reading = '0;
	int          wait_ms      = 0;
	int          attempts     = 0;

	rsp_pkg::rsp_result_t expected_out [$];
	poll_req_t            pending_reqs [$];
	int                   reqs_queued  = 0;
	int                   reqs_taken   = 0;
	int                   mismatches   = 0;

	// Builds the request frame (bytes then CRC low, CRC high) and enters the wait.
	// The receive store is emptied on every send.
	task automatic build_request(output logic [8*(REQ_LEN+2)-1:0] tx, output int n);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = rsp_pkg::CRC_INIT;
		tx  = '0;
		for (int i = 0; i < REQ_LEN; i++) begin
			// bytes past the sixth go out as zero
			if (i < 6) begin
				b = frame_cfg[rsp_pkg::FRAME_W-1-8*i -: 8];
			end else begin
				b = 8'h00;
			end
			crc ^= {8'h00, b};
			for (int k = 0; k < 8; k++) begin
				crc = crc[0] ? ((crc >> 1) ^ rsp_pkg::CRC_POLY) : (crc >> 1);
			end
			tx[8*i +: 8] = b;
		end
		tx[8*REQ_LEN +: 8]     = crc[7:0];
		tx[8*REQ_LEN + 8 +: 8] = crc[15:8];
		n            = REQ_LEN + 2;
		rx_fill      = 0;
		line_waiting = 1'b1;
		wait_ms      = 0;
		// attempts only count while a read is armed, and stick at the top
		if (read_armed && attempts < rsp_pkg::RETRY_MAX) begin
			attempts++;
		end
	endtask

	// One accepted request: update state and queue the results it causes.
	task automatic poller_step(input logic [1:0] op, input logic [7:0] rx);
		logic [8*(REQ_LEN+2)-1:0] tx;
		int                       n;
		logic [1:0]               st;
		logic [15:0]              v;
		logic                     sent;
		rsp_pkg::rsp_result_t     r;
		tx = '0;
		n  = 0;
		st = rsp_pkg::STATUS_NONE;
		case (op)
			rsp_pkg::OP_POLL: begin
				if (!line_waiting) begin
					// sent even when no read is armed
					build_request(tx, n);
				end else if (rx_fill >= RSP_LEN) begin
					v = {rx_bytes[3], rx_bytes[4]};
					if (v != 16'h0000) begin
						held_reading = v;
						st           = rsp_pkg::STATUS_NEW;
					end else begin
						st = rsp_pkg::STATUS_ZERO;
					end
					rx_fill      = 0;
					line_waiting = 1'b0;
					read_armed   = 1'b0;
				end
			end
			rsp_pkg::OP_RX: begin
				// full store drops further bytes
				if (rx_fill < RSP_LEN) begin
					rx_bytes[rx_fill] = rx;
					rx_fill++;
				end
			end
			rsp_pkg::OP_TICK: begin
				// unarmed or idle: ignored
				if (read_armed && line_waiting) begin
					if (wait_ms < rsp_pkg::ELAPSED_MAX) begin
						wait_ms++;
					end
					if (wait_ms >= timeout_cfg) begin
						if (attempts >= retries_cfg) begin
							line_waiting = 1'b0;
							read_armed   = 1'b0;
							st           = rsp_pkg::STATUS_FAIL;
						end else begin
							build_request(tx, n);
						end
					end
				end
			end
			rsp_pkg::OP_START: begin
				// also abandons a wait in progress
				read_armed   = 1'b1;
				line_waiting = 1'b0;
				attempts     = 0;
				wait_ms      = 0;
			end
			default: ;
		endcase
		sent = (n != 0);
		if (!sent) begin
			n = 1;
		end
		for (int i = 0; i < n; i++) begin
			r.tx_byte  = sent ? tx[8*i +: 8] : 8'h00;
			r.tx_valid = sent;
			r.reading  = held_reading;
			r.mode     = line_waiting;
			r.status   = st;
			r.last     = (i == n - 1);
			expected_out.push_back(r);
		end
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
	                                    input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Request driver (falling edge)
	// ---------------------------------------------------------------
	int        reqs_seen = 0;      // accepts already accounted for by the driver
	logic      steady    = 1'b0;   // no gaps on either side
	logic      hold_req  = 1'b0;   // ask the sink for one long hold-off
	logic      hold_done = 1'b0;   // the hold-off has been served
	int        hold_left = 0;
	poll_req_t cur_req;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || reqs_taken != reqs_seen) begin
			if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				cur_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= cur_req.op;
				s_tdata  <= cur_req.rx;
			end else begin
				s_tvalid <= 1'b0;
				s_tuser  <= 2'($urandom);
				s_tdata  <= 8'($urandom);
			end
		end
		reqs_seen = reqs_taken;
	end

	// Result sink: random back-pressure plus one long hold-off on request.
	// The hold-off is counted here while the driver keeps offering requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------
	// Monitor (rising edge): predict on input, compare on output, watchdog
	// ---------------------------------------------------------------
	rsp_pkg::rsp_result_t seen;
	rsp_pkg::rsp_result_t want;
	int                   quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			poller_step(s_tuser, s_tdata);
			reqs_taken++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			seen.tx_byte  = m_tdata[7:0];
			seen.reading  = m_tdata[23:8];
			seen.mode     = m_tdata[24];
			seen.status   = m_tdata[26:25];
			seen.tx_valid = m_tuser;
			seen.last     = m_tlast;
			if (expected_out.size() == 0) begin
				$error("result with nothing expected: tdata %0h", m_tdata);
				mismatches++;
			end else begin
				want = expected_out.pop_front();
				check_field("tx_byte", 16'(want.tx_byte), 16'(seen.tx_byte));
				check_field("tx_valid", 16'(want.tx_valid), 16'(seen.tx_valid));
				check_field("reading", want.reading, seen.reading);
				check_field("mode", 16'(want.mode), 16'(seen.mode));
				check_field("status", 16'(want.status), 16'(seen.status));
				check_field("last", 16'(want.last), 16'(seen.last));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic add_req(input logic [1:0] op, input logic [7:0] rx);
		poll_req_t q;
		q.op = op;
		q.rx = rx;
		pending_reqs.push_back(q);
		reqs_queued++;
	endtask

	// wait for every request in and every result out, then let the block go quiet
	task automatic settle();
		while (reqs_taken != reqs_queued || expected_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write while idle; the prediction takes the value at once
	task automatic write_reg(input logic [rsp_pkg::CFG_ADDR_W-1:0] idx,
	                         input logic [rsp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsp_pkg::REG_FRAME:   frame_cfg   = val[rsp_pkg::FRAME_W-1:0];
			rsp_pkg::REG_TIMEOUT: timeout_cfg = val[rsp_pkg::TIMEOUT_W-1:0];
			rsp_pkg::REG_RETRIES: retries_cfg = val[rsp_pkg::RETRY_W-1:0];
			default:              ;
		endcase
	endtask

	// Mostly read cycles (start, poll, a few ticks, a reply, poll) with random content,
	// some with a short reply or a surplus byte; the rest short bursts of random requests.
	task automatic queue_read_cycles(input int count);
		int         sel;
		int         ticks;
		int         nbytes;
		logic       zero_val;
		logic [7:0] b;
		for (int c = 0; c < count; c++) begin
			sel = $urandom_range(99);
			if (sel < 75) begin
				if ($urandom_range(9) != 0) begin
					add_req(rsp_pkg::OP_START, 8'($urandom));
				end
				add_req(rsp_pkg::OP_POLL, 8'($urandom));
				ticks = $urandom_range(0, 3);
				repeat (ticks) add_req(rsp_pkg::OP_TICK, 8'($urandom));
				zero_val = ($urandom_range(4) == 0);
				nbytes   = ($urandom_range(4) == 0) ? int'($urandom_range(0, RSP_LEN - 1))
				                                    : int'(RSP_LEN);
				for (int j = 0; j < nbytes; j++) begin
					b = 8'($urandom);
					if (zero_val && (j == 3 || j == 4)) begin
						b = 8'h00;
					end
					add_req(rsp_pkg::OP_RX, b);
				end
				if ($urandom_range(3) == 0) begin
					add_req(rsp_pkg::OP_RX, 8'($urandom));
				end
				add_req(rsp_pkg::OP_POLL, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) add_req(2'($urandom_range(0, 3)), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: unarmed poll still sends, unarmed wait ignores ticks,
		// full store drops a surplus byte, most negative reading
		add_req(rsp_pkg::OP_POLL, 8'hFF);
		add_req(rsp_pkg::OP_TICK, 8'h00);
		add_req(rsp_pkg::OP_RX, 8'h00);
		add_req(rsp_pkg::OP_RX, 8'hFF);
		add_req(rsp_pkg::OP_RX, 8'h5A);
		add_req(rsp_pkg::OP_RX, 8'h80);
		add_req(rsp_pkg::OP_RX, 8'h00);
		add_req(rsp_pkg::OP_RX, 8'hA5);
		add_req(rsp_pkg::OP_RX, 8'h01);
		add_req(rsp_pkg::OP_RX, 8'h3C);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		settle();

		// all-ones frame, quickest timeout: resend, then retries exhausted;
		// start abandons a wait; an all-zero value is rejected
		write_reg(rsp_pkg::REG_FRAME, 48'hFFFF_FFFF_FFFF);
		write_reg(rsp_pkg::REG_TIMEOUT, 48'd1);
		write_reg(rsp_pkg::REG_RETRIES, 48'd2);
		add_req(rsp_pkg::OP_START, 8'h00);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		add_req(rsp_pkg::OP_TICK, 8'h00);
		add_req(rsp_pkg::OP_TICK, 8'h00);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		add_req(rsp_pkg::OP_START, 8'h00);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		repeat (RSP_LEN) add_req(rsp_pkg::OP_RX, 8'h00);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		settle();

		// zero timeout and zero retries: the first tick of the wait fails
		write_reg(rsp_pkg::REG_TIMEOUT, 48'd0);
		write_reg(rsp_pkg::REG_RETRIES, 48'd0);
		add_req(rsp_pkg::OP_START, 8'h00);
		add_req(rsp_pkg::OP_POLL, 8'h00);
		add_req(rsp_pkg::OP_TICK, 8'h00);
		settle();

		// random frame, short timeout, no gaps on either side
		write_reg(rsp_pkg::REG_FRAME, 48'({$urandom, $urandom}));
		write_reg(rsp_pkg::REG_TIMEOUT, 48'($urandom_range(1, 3)));
		write_reg(rsp_pkg::REG_RETRIES, 48'($urandom_range(1, 4)));
		steady = 1'b1;
		queue_read_cycles(3);
		settle();
		steady = 1'b0;

		// top retry count with a long sink hold-off: the block backs up
		write_reg(rsp_pkg::REG_FRAME, 48'({$urandom, $urandom}));
		write_reg(rsp_pkg::REG_TIMEOUT, 48'd2);
		write_reg(rsp_pkg::REG_RETRIES, 48'd15);
		hold_req = 1'b1;
		queue_read_cycles(3);
		settle();

		// longest timeout: ticks never expire the wait
		write_reg(rsp_pkg::REG_FRAME, 48'h0103_0000_0001);
		write_reg(rsp_pkg::REG_TIMEOUT, 48'd65535);
		write_reg(rsp_pkg::REG_RETRIES, 48'd1);
		queue_read_cycles(1);
		settle();

		write_reg(rsp_pkg::REG_FRAME, 48'({$urandom, $urandom}));
		write_reg(rsp_pkg::REG_TIMEOUT, 48'($urandom_range(1, 5)));
		write_reg(rsp_pkg::REG_RETRIES, 48'($urandom_range(1, 15)));
		queue_read_cycles(2);
		settle();

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/rsp_pkg.sv
rtl/core/rsp_crc16.sv
rtl/core/rsp_out_reg.sv
rtl/core/rs485_sensor_poll_master.sv
rtl/core/rsp_checker.sv
tb/tb_top.sv
